FILE: sv/hsfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsfr_pkg
// Shared types and constants of the header-synchronized sum-checked frame
// receiver.
// ----------------------------------------------------------------------------
package hsfr_pkg;

    localparam int FRAME_LEN = 8;                       // bytes per frame, 3..64
    localparam int DATA_W    = 8;
    localparam int IDX_W     = 6;                       // width of the byte index port
    localparam int ADDR_W    = $clog2(FRAME_LEN);
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);

    localparam logic [DATA_W-1:0] ROBOT_TAG    = 8'h10;
    localparam logic [DATA_W-1:0] HEADER_RESET = 8'hAA;

    // Register index, taken from paddr[2].
    localparam logic REG_HEADER = 1'b0;

    typedef enum logic [1:0] {
        S_HUNT,
        S_FILL,
        S_READ,
        S_LOAD
    } t_state;

endpackage
`default_nettype wire

FILE: sv/header_sync_sum_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// header_sync_sum_frame_receiver
// Hunts for the header byte, stores a frame in a small memory while summing
// it, and streams the frame back out when the checksum byte matches.
// ----------------------------------------------------------------------------
// Input: one byte per cycle is taken while hunting or filling a frame.
// Output: after the checksum byte of a good frame is accepted, each frame
// byte is sent as a memory read (S_READ) followed by an output load
// (S_LOAD); the read waits while the output register is still full, and
// the input is blocked until the last frame byte has been loaded.
// Reset (synchronous, active low) returns to hunting and sets the header to
// 0xAA; the frame memory is not cleared.
// ----------------------------------------------------------------------------
module header_sync_sum_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // received bytes
    input  wire logic                        i_rx_valid,
    output logic                             o_rx_ready,
    input  wire logic [hsfr_pkg::DATA_W-1:0] i_rx_byte,
    // frame bytes
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [hsfr_pkg::DATA_W-1:0] o_frame_byte,
    output logic      [hsfr_pkg::IDX_W-1:0]  o_byte_index,
    output logic                             o_robot_frame,
    output logic                             o_last_byte
);

    import hsfr_pkg::*;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [DATA_W-1:0]   r_sum, n_sum;
    logic                r_robot, n_robot;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_byte;
    logic [IDX_W-1:0]    r_out_index;
    logic                r_out_robot;
    logic                r_out_last;
    logic [DATA_W-1:0]   r_header;

    logic                rx_acc;
    logic                cfg_wr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic                load;
    logic [DATA_W-1:0]   rd_data;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEADER) ? {{(32-DATA_W){1'b0}}, r_header} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (cfg_wr && paddr[2] == REG_HEADER) begin
            r_header <= pwdata[DATA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Frame memory
    // ------------------------------------------------------------------
    hsfr_ram #(
        .DEPTH(FRAME_LEN),
        .WIDTH(DATA_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_rx_byte),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign o_rx_ready = (r_state == S_HUNT) || (r_state == S_FILL);
    assign rx_acc     = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_robot     = r_robot;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = r_fill[ADDR_W-1:0];
        rd_en       = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            S_HUNT: begin
                if (rx_acc && i_rx_byte == r_header) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_fill  = FILL_W'(1);
                    n_sum   = i_rx_byte;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (rx_acc) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + FILL_W'(1);
                    if (r_fill == FILL_W'(1)) begin
                        n_robot = (i_rx_byte == ROBOT_TAG);
                    end
                    // The last byte is the checksum and is not added in.
                    if (r_fill == FILL_W'(FRAME_LEN - 1)) begin
                        n_fill  = '0;
                        n_idx   = '0;
                        n_state = (r_sum == i_rx_byte) ? S_READ : S_HUNT;
                    end else begin
                        n_sum = r_sum + i_rx_byte;
                    end
                end
            end
            S_READ: begin
                // Only read once the output register will be free next cycle.
                if (!r_out_valid || i_out_ready) begin
                    rd_en   = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                load        = 1'b1;
                n_out_valid = 1'b1;
                if (r_idx == ADDR_W'(FRAME_LEN - 1)) begin
                    n_state = S_HUNT;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_READ;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_robot <= n_robot;
        r_idx   <= n_idx;
        if (load) begin
            r_out_byte  <= rd_data;
            r_out_index <= IDX_W'(r_idx);
            r_out_robot <= r_robot;
            r_out_last  <= (r_idx == ADDR_W'(FRAME_LEN - 1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_byte  = r_out_byte;
    assign o_byte_index  = r_out_index;
    assign o_robot_frame = r_out_robot;
    assign o_last_byte   = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> (r_fill != '0) && (r_fill < FILL_W'(FRAME_LEN)))
        else $error("fill count out of range while filling a frame");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> !r_out_valid)
        else $error("output register still full when a frame byte is loaded");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_state == S_LOAD)
        else $error("memory read not followed by an output load");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> o_out_valid)
        else $error("loaded frame byte not presented");

    a_no_write_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_LOAD) |-> !wr_en)
        else $error("frame memory written while a frame is being sent");

endmodule
`default_nettype wire

FILE: sv/hsfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsfr_ram
// Single-port-write, single-port-read synchronous memory with a registered
// read port.
// ----------------------------------------------------------------------------
module hsfr_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: dv/hsfr_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsfr_frame_checker
// Watches the register port and both byte channels of the frame receiver,
// keeps its own model of the header hunt, the frame buffer and the running
// sum, and compares every frame byte that leaves the block with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module hsfr_frame_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [2:0]                  i_paddr,
    input  wire logic [31:0]                 i_pwdata,
    input  wire logic                        i_pready,
    input  wire logic                        i_rx_valid,
    input  wire logic                        i_rx_ready,
    input  wire logic [hsfr_pkg::DATA_W-1:0] i_rx_byte,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [hsfr_pkg::DATA_W-1:0] i_frame_byte,
    input  wire logic [hsfr_pkg::IDX_W-1:0]  i_byte_index,
    input  wire logic                        i_robot_frame,
    input  wire logic                        i_last_byte,
    output int                               o_error_count,
    output int                               o_pending_beats,
    output int                               o_good_frames
);

    import hsfr_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              robot;
        logic              last;
    } t_frame_beat;

    t_frame_beat       expected_beats[$];
    t_frame_beat       head_beat;
    logic [DATA_W-1:0] header_reg;
    logic [DATA_W-1:0] frame_mem [FRAME_LEN];
    logic [DATA_W-1:0] sum_acc;
    logic              filling;
    int                fill_level;
    int                error_count = 0;
    int                good_frames = 0;

    task automatic report(input string what);
        error_count++;
        $display("%0t ns  MISMATCH: %s", $time, what);
    endtask

    task automatic take_rx_byte(input logic [DATA_W-1:0] b);
        t_frame_beat beat;
        logic        robot_tag;
        if (!filling) begin
            if (b == header_reg) begin
                filling      = 1'b1;
                frame_mem[0] = b;
                fill_level   = 1;
                sum_acc      = b;
            end
        end else begin
            frame_mem[fill_level] = b;
            fill_level++;
            if (fill_level < FRAME_LEN) begin
                sum_acc = sum_acc + b;
            end else begin
                // The last byte closes the frame whether or not it matches.
                filling    = 1'b0;
                fill_level = 0;
                if (sum_acc == b) begin
                    robot_tag = (frame_mem[1] == ROBOT_TAG);
                    for (int k = 0; k < FRAME_LEN; k++) begin
                        beat.data  = frame_mem[k];
                        beat.index = IDX_W'(k);
                        beat.robot = robot_tag;
                        beat.last  = (k == FRAME_LEN - 1);
                        expected_beats.push_back(beat);
                    end
                end
                sum_acc = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            header_reg = HEADER_RESET;
            filling    = 1'b0;
            fill_level = 0;
            sum_acc    = '0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report($sformatf("unexpected item: byte %02h index %0d",
                                     i_frame_byte, i_byte_index));
                end else begin
                    head_beat = expected_beats.pop_front();
                    if (i_frame_byte !== head_beat.data)
                        report($sformatf("frame_byte %02h, expected %02h (index %0d)",
                                         i_frame_byte, head_beat.data, head_beat.index));
                    if (i_byte_index !== head_beat.index)
                        report($sformatf("byte_index %0d, expected %0d",
                                         i_byte_index, head_beat.index));
                    if (i_robot_frame !== head_beat.robot)
                        report($sformatf("robot_frame %b, expected %b (index %0d)",
                                         i_robot_frame, head_beat.robot, head_beat.index));
                    if (i_last_byte !== head_beat.last)
                        report($sformatf("last_byte %b, expected %b (index %0d)",
                                         i_last_byte, head_beat.last, head_beat.index));
                    if (head_beat.last)
                        good_frames++;
                end
            end
            // A byte taken at the same edge as a header write still sees the old header.
            if (i_rx_valid && i_rx_ready)
                take_rx_byte(i_rx_byte);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_HEADER) begin
                header_reg = i_pwdata[DATA_W-1:0];
            end
        end
        o_error_count   <= error_count;
        o_pending_beats <= expected_beats.size();
        o_good_frames   <= good_frames;
    end

endmodule

FILE: dv/tb_header_sync_sum_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_header_sync_sum_frame_receiver
// Drives serial bytes and header settings into the frame receiver: a short
// directed sequence, then mixed good, corrupted, truncated and noise traffic
// under several header values, with bursty input and a stalling output side.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_header_sync_sum_frame_receiver;
    import hsfr_pkg::*;

    localparam logic [2:0] HEADER_ADDR   = {REG_HEADER, 2'b00};
    localparam logic [2:0] SPARE_ADDR    = {~REG_HEADER, 2'b00};
    localparam int         SETTLE_CYCLES = 2 * FRAME_LEN + 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         RANDOM_PHASES = 5;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_rx_valid;
    logic              o_rx_ready;
    logic [DATA_W-1:0] i_rx_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_frame_byte;
    logic [IDX_W-1:0]  o_byte_index;
    logic              o_robot_frame;
    logic              o_last_byte;

    int                error_count;
    int                pending_beats;
    int                good_frames;

    logic [DATA_W-1:0] frame_body [FRAME_LEN-2];
    logic [DATA_W-1:0] cur_header    = HEADER_RESET;
    int                burst_left    = 0;
    int                bytes_sent    = 0;
    int                header_writes = 0;
    bit                long_hold_req  = 1'b0;
    bit                long_hold_done = 1'b0;

    header_sync_sum_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_byte  (o_frame_byte),
        .o_byte_index  (o_byte_index),
        .o_robot_frame (o_robot_frame),
        .o_last_byte   (o_last_byte)
    );

    hsfr_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .i_rx_valid      (i_rx_valid),
        .i_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_frame_byte    (o_frame_byte),
        .i_byte_index    (o_byte_index),
        .i_robot_frame   (o_robot_frame),
        .i_last_byte     (o_last_byte),
        .o_error_count   (error_count),
        .o_pending_beats (pending_beats),
        .o_good_frames   (good_frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == HEADER_ADDR)
            header_writes++;
    endtask

    // Valid stays high across a burst; a gap is opened only when the burst
    // is used up.
    task automatic send_byte(input logic [DATA_W-1:0] b);
        int gap;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic rx_drain();
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] body_sum(input logic [DATA_W-1:0] hdr);
        logic [DATA_W-1:0] sum;
        sum = hdr;
        for (int k = 0; k < FRAME_LEN - 2; k++)
            sum = sum + frame_body[k];
        return sum;
    endfunction

    task automatic send_frame(input logic [DATA_W-1:0] hdr, input bit corrupt);
        logic [DATA_W-1:0] check;
        check = body_sum(hdr);
        if (corrupt)
            check = check ^ 8'($urandom_range(1, 255));
        send_byte(hdr);
        for (int k = 0; k < FRAME_LEN - 2; k++)
            send_byte(frame_body[k]);
        send_byte(check);
    endtask

    task automatic fill_body(input bit robot);
        for (int k = 0; k < FRAME_LEN - 2; k++)
            frame_body[k] = 8'($urandom_range(0, 255));
        if (robot)
            frame_body[0] = ROBOT_TAG;
    endtask

    task automatic send_mixed_frame();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 7) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
            // A frame cut short: the bytes that follow finish it off.
            send_byte(cur_header);
            repeat ($urandom_range(1, FRAME_LEN - 2)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            fill_body(kind == 9 || $urandom_range(0, 3) == 0);
            send_frame(cur_header, kind == 6);
        end
    endtask

    // Output side: a stall pattern that steps through four modes in turn, plus
    // one long hold-off on request.
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (long_hold_req && !long_hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                unique case ((rx_cycle / 50) % 4)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_rx_valid <= 1'b0;
        i_rx_byte  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // A write to the unused address must leave the header alone.
        apb_write(SPARE_ADDR, 32'h0000_0055);

        send_byte(8'h00);
        send_byte(8'hFF);
        // Robot frame carrying the header value and both byte extremes.
        frame_body = '{ROBOT_TAG, HEADER_RESET, 8'hFF, 8'h00, 8'h01, 8'h80};
        send_frame(HEADER_RESET, 1'b0);
        frame_body = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
        send_frame(HEADER_RESET, 1'b1);
        // The header changes halfway through a frame; that frame still completes.
        frame_body = '{8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFE};
        send_byte(HEADER_RESET);
        for (int k = 0; k < 3; k++)
            send_byte(frame_body[k]);
        rx_drain();
        cur_header = 8'h00;
        apb_write(HEADER_ADDR, {24'h0, cur_header});
        for (int k = 3; k < FRAME_LEN - 2; k++)
            send_byte(frame_body[k]);
        send_byte(body_sum(HEADER_RESET));
        rx_drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       cur_header = 8'hFF;
                2:       cur_header = ROBOT_TAG;
                3:       cur_header = 8'h00;
                default: cur_header = 8'($urandom_range(0, 255));
            endcase
            apb_write(HEADER_ADDR, {24'($urandom_range(0, 32'h00FF_FFFF)), cur_header});
            if (p == 1)
                long_hold_req = 1'b1;
            repeat (7) send_mixed_frame();
            rx_drain();
        end

        $display("Run summary: %0d bytes offered under %0d header settings, bursty input.",
                 bytes_sent, header_writes);
        $display("Run summary: %0d frames streamed out, one behind a %0d-cycle output hold.",
                 good_frames, HOLD_CYCLES);
        if (error_count == 0 && pending_beats == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: header_sync_sum_frame_receiver.f
sv/hsfr_pkg.sv
sv/hsfr_ram.sv
sv/header_sync_sum_frame_receiver.sv
dv/hsfr_frame_checker.sv
dv/tb_header_sync_sum_frame_receiver.sv
